/* hdl/fault_code_store_defines.svh */
// Assertion macros used by the fault code store sequencer (fc_ctrl).
`ifndef FAULT_CODE_STORE_DEFINES_SVH
`define FAULT_CODE_STORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define FC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/fc_pkg.sv */
// Package: action codes, sequencer states and result record of the fault code store.
`timescale 1ns / 1ps
`default_nettype none

package fc_pkg;

    // Field widths of the stream payload
    localparam int ACTION_W    = 3;
    localparam int IN_CODE_W   = 16;
    localparam int COUNT_W     = 8;
    localparam int ACT_TOTAL_W = 4;
    localparam int HIS_TOTAL_W = 5;
    localparam int OUT_CODE_W  = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET        = 3'd0,
        ACT_CLEAR      = 3'd1,
        ACT_CLEAR_ALL  = 3'd2,
        ACT_QUERY      = 3'd3,
        ACT_READ_ACT   = 3'd4,
        ACT_READ_HIST  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_A,
        ST_SCAN_H,
        ST_SHIFT,
        ST_BURST_RD,
        ST_BURST,
        ST_DONE
    } t_state;

    // One result handed from the sequencer to the output register
    typedef struct packed {
        logic                   load;
        logic                   code_active;
        logic [ACT_TOTAL_W-1:0] active_total;
        logic [HIS_TOTAL_W-1:0] history_total;
        logic [OUT_CODE_W-1:0]  read_code;
        logic                   read_valid;
        logic                   last;
    } t_result;

endpackage

`default_nettype wire

/* hdl/fault_code_store.sv */
// Top level of the fault code store: stream ports, list memories and output register.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one action: set, clear, clear all, query or read
//  m_axis   | out       | status result, or one list entry of a read burst
//
// After accept, every action but a clear all walks the active list through the single
// comparator at one entry a cycle. A set walks the history list the same way, a clear shifts
// later entries down at one a cycle, a read streams min(fill, max_count) entries after the
// burst read state, each held until the output register takes it.
// Reset clears only the fill counts; entries above the fill are never read.
// A stalled output holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none

module fault_code_store #(
    parameter int ACTIVE_DEPTH  = 8,
    parameter int HISTORY_DEPTH = 16,
    parameter int CODE_WIDTH    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] action, [18:3] fault_code, [26:19] max_count, [31:27] zero
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] code_active, [4:1] active_total, [9:5] history_total,
    // [25:10] read_code, [31:26] zero
    output logic [31:0]      m_axis_tdata,
    // [0] read_valid
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    import fc_pkg::*;

    localparam int A_AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int H_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic                  a_we, a_re, h_we, h_re;
    logic [A_AW-1:0]       a_waddr, a_raddr;
    logic [H_AW-1:0]       h_waddr, h_raddr;
    logic [CODE_WIDTH-1:0] a_wdata, a_rdata, h_wdata, h_rdata;
    logic                  out_free;
    t_result               res;

    logic                   r_m_valid;
    logic                   r_code_active;
    logic [ACT_TOTAL_W-1:0] r_active_total;
    logic [HIS_TOTAL_W-1:0] r_history_total;
    logic [OUT_CODE_W-1:0]  r_read_code;
    logic                   r_read_valid;
    logic                   r_last;

    assign out_free = !r_m_valid || m_axis_tready;

    fc_ctrl #(
        .ACTIVE_DEPTH  (ACTIVE_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CODE_WIDTH    (CODE_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tdata[2:0]),
        .i_fault_code (s_axis_tdata[18:3]),
        .i_max_count  (s_axis_tdata[26:19]),
        .i_out_free   (out_free),
        .o_res        (res),
        .o_a_we       (a_we),
        .o_a_waddr    (a_waddr),
        .o_a_wdata    (a_wdata),
        .o_a_re       (a_re),
        .o_a_raddr    (a_raddr),
        .i_a_rdata    (a_rdata),
        .o_h_we       (h_we),
        .o_h_waddr    (h_waddr),
        .o_h_wdata    (h_wdata),
        .o_h_re       (h_re),
        .o_h_raddr    (h_raddr),
        .i_h_rdata    (h_rdata)
    );

    fc_ram #(
        .DEPTH (ACTIVE_DEPTH),
        .WIDTH (CODE_WIDTH)
    ) u_active_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    fc_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (CODE_WIDTH)
    ) u_history_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res.load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_code_active   <= res.code_active;
            r_active_total  <= res.active_total;
            r_history_total <= res.history_total;
            r_read_code     <= res.read_code;
            r_read_valid    <= res.read_valid;
            r_last          <= res.last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_read_code, r_history_total, r_active_total, r_code_active};
    assign m_axis_tuser  = r_read_valid;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

/* hdl/fc_ram.sv */
// Single-write, single-read list memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fc_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/fc_ctrl.sv */
// Sequencer with the shared code comparator and the fill counters of both lists.
`timescale 1ns / 1ps
`default_nettype none

`include "fault_code_store_defines.svh"

module fc_ctrl #(
    parameter int ACTIVE_DEPTH  = 8,
    parameter int HISTORY_DEPTH = 16,
    parameter int CODE_WIDTH    = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    // incoming transaction
    input  wire logic                                         i_valid,
    output logic                                              o_ready,
    input  wire logic [fc_pkg::ACTION_W-1:0]                  i_action,
    input  wire logic [fc_pkg::IN_CODE_W-1:0]                 i_fault_code,
    input  wire logic [fc_pkg::COUNT_W-1:0]                   i_max_count,
    // result towards the output register
    input  wire logic                                         i_out_free,
    output fc_pkg::t_result                                   o_res,
    // active list memory
    output logic                                              o_a_we,
    output logic [(ACTIVE_DEPTH > 1 ? $clog2(ACTIVE_DEPTH) : 1)-1:0] o_a_waddr,
    output logic [CODE_WIDTH-1:0]                             o_a_wdata,
    output logic                                              o_a_re,
    output logic [(ACTIVE_DEPTH > 1 ? $clog2(ACTIVE_DEPTH) : 1)-1:0] o_a_raddr,
    input  wire logic [CODE_WIDTH-1:0]                        i_a_rdata,
    // history list memory
    output logic                                              o_h_we,
    output logic [(HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1)-1:0] o_h_waddr,
    output logic [CODE_WIDTH-1:0]                             o_h_wdata,
    output logic                                              o_h_re,
    output logic [(HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1)-1:0] o_h_raddr,
    input  wire logic [CODE_WIDTH-1:0]                        i_h_rdata
);

    import fc_pkg::*;

    localparam int A_AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int H_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int AFW  = $clog2(ACTIVE_DEPTH + 1);
    localparam int HFW  = $clog2(HISTORY_DEPTH + 1);
    localparam int MAXD = (ACTIVE_DEPTH > HISTORY_DEPTH) ? ACTIVE_DEPTH : HISTORY_DEPTH;
    localparam int IW   = $clog2(MAXD + 1);

    t_state                r_state, n_state;
    t_action               r_action, n_action;
    logic [CODE_WIDTH-1:0] r_code, n_code;
    logic [COUNT_W-1:0]    r_maxc, n_maxc;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [IW-1:0]         r_pidx, n_pidx;
    logic                  r_flag, n_flag;
    logic [IW-1:0]         r_n, n_n;
    logic [AFW-1:0]        r_a_fill, n_a_fill;
    logic [HFW-1:0]        r_h_fill, n_h_fill;

    logic                  a_more, h_more;
    logic                  a_room, h_room;
    logic                  a_cmp, h_cmp;
    logic [CODE_WIDTH-1:0] cmp_data;
    logic                  cmp_hit;
    logic [COUNT_W-1:0]    sel_fill;
    logic [COUNT_W-1:0]    read_n;
    logic [IW-1:0]         idx_inc;
    logic                  burst_last;
    logic [CODE_WIDTH-1:0] burst_data;
    t_action               in_action;

    assign in_action = t_action'(i_action);

    // Walk position against fill
    assign a_more  = r_idx < IW'(r_a_fill);
    assign h_more  = r_idx < IW'(r_h_fill);
    assign a_room  = r_a_fill < AFW'(ACTIVE_DEPTH);
    assign h_room  = r_h_fill < HFW'(HISTORY_DEPTH);
    assign idx_inc = r_idx + IW'(1);

    // The one comparator, fed from whichever list is being walked
    assign cmp_data = (r_state == ST_SCAN_H) ? i_h_rdata : i_a_rdata;
    assign cmp_hit  = r_pend && (cmp_data == r_code);
    assign a_cmp    = cmp_hit && (r_state == ST_SCAN_A);
    assign h_cmp    = cmp_hit && (r_state == ST_SCAN_H);

    // Burst length: min(fill, max_count)
    assign sel_fill = (r_action == ACT_READ_HIST) ? COUNT_W'(r_h_fill) : COUNT_W'(r_a_fill);
    assign read_n   = (sel_fill < r_maxc) ? sel_fill : r_maxc;

    assign burst_last = (idx_inc == r_n);
    assign burst_data = (r_action == ACT_READ_HIST) ? i_h_rdata : i_a_rdata;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (in_action == ACT_CLEAR_ALL) ? ST_DONE : ST_SCAN_A;
                end
            end
            ST_SCAN_A: begin
                if (a_cmp || !a_more) begin
                    unique case (r_action)
                        ACT_SET:       n_state = ST_SCAN_H;
                        ACT_CLEAR:     n_state = a_cmp ? ST_SHIFT : ST_DONE;
                        ACT_READ_ACT,
                        ACT_READ_HIST: n_state = (read_n == '0) ? ST_DONE : ST_BURST_RD;
                        default:       n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_H: begin
                if (h_cmp || !h_more) begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (!a_more && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_BURST_RD: begin
                n_state = ST_BURST;
            end
            ST_BURST: begin
                if (i_out_free && burst_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and results
    always_comb begin
        n_action = r_action;
        n_code   = r_code;
        n_maxc   = r_maxc;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_flag   = r_flag;
        n_n      = r_n;
        n_a_fill = r_a_fill;
        n_h_fill = r_h_fill;

        o_ready   = 1'b0;
        o_a_we    = 1'b0;
        o_a_waddr = A_AW'(r_a_fill);
        o_a_wdata = r_code;
        o_a_re    = 1'b0;
        o_a_raddr = A_AW'(r_idx);
        o_h_we    = 1'b0;
        o_h_waddr = H_AW'(r_h_fill);
        o_h_wdata = r_code;
        o_h_re    = 1'b0;
        o_h_raddr = H_AW'(r_idx);

        o_res               = '0;
        o_res.code_active   = r_flag;
        o_res.active_total  = ACT_TOTAL_W'(r_a_fill);
        o_res.history_total = HIS_TOTAL_W'(r_h_fill);

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_action = in_action;
                    n_code   = CODE_WIDTH'(i_fault_code);
                    n_maxc   = i_max_count;
                    n_idx    = '0;
                    if (in_action == ACT_CLEAR_ALL) begin
                        n_a_fill = '0;
                        n_flag   = 1'b0;
                    end
                end
            end
            ST_SCAN_A: begin
                // issue the next entry while comparing the previous one
                o_a_re = a_more;
                n_pend = a_more;
                n_pidx = r_idx;
                if (a_more) begin
                    n_idx = idx_inc;
                end
                if (a_cmp || !a_more) begin
                    n_pend = 1'b0;
                    n_idx  = '0;
                    unique case (r_action)
                        ACT_SET: begin
                            n_flag = a_cmp || a_room;
                            if (!a_cmp && a_room) begin
                                o_a_we   = 1'b1;
                                n_a_fill = r_a_fill + AFW'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_flag = 1'b0;
                            n_idx  = r_pidx + IW'(1);
                        end
                        ACT_READ_ACT,
                        ACT_READ_HIST: begin
                            n_flag = a_cmp;
                            n_n    = IW'(read_n);
                        end
                        default: begin
                            n_flag = a_cmp;
                        end
                    endcase
                end
            end
            ST_SCAN_H: begin
                o_h_re = h_more;
                n_pend = h_more;
                n_pidx = r_idx;
                if (h_more) begin
                    n_idx = idx_inc;
                end
                if (h_cmp || !h_more) begin
                    n_pend = 1'b0;
                    if (!h_cmp && h_room) begin
                        o_h_we   = 1'b1;
                        n_h_fill = r_h_fill + HFW'(1);
                    end
                end
            end
            ST_SHIFT: begin
                // read entry k, write it to k-1 in the cycle after
                o_a_re = a_more;
                n_pend = a_more;
                n_pidx = r_idx;
                if (a_more) begin
                    n_idx = idx_inc;
                end
                if (r_pend) begin
                    o_a_we    = 1'b1;
                    o_a_waddr = A_AW'(r_pidx - IW'(1));
                    o_a_wdata = i_a_rdata;
                end
                if (!a_more && !r_pend) begin
                    n_a_fill = r_a_fill - AFW'(1);
                end
            end
            ST_BURST_RD: begin
                if (r_action == ACT_READ_HIST) begin
                    o_h_re = 1'b1;
                end else begin
                    o_a_re = 1'b1;
                end
            end
            ST_BURST: begin
                o_res.load       = i_out_free;
                o_res.read_code  = OUT_CODE_W'(burst_data);
                o_res.read_valid = 1'b1;
                o_res.last       = burst_last;
                if (i_out_free && !burst_last) begin
                    n_idx     = idx_inc;
                    o_a_raddr = A_AW'(idx_inc);
                    o_h_raddr = H_AW'(idx_inc);
                    if (r_action == ACT_READ_HIST) begin
                        o_h_re = 1'b1;
                    end else begin
                        o_a_re = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                // status result, also the empty read
                o_res.load = i_out_free;
                o_res.last = 1'b1;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_a_fill <= '0;
            r_h_fill <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_a_fill <= n_a_fill;
            r_h_fill <= n_h_fill;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_code   <= n_code;
        r_maxc   <= n_maxc;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_flag   <= n_flag;
        r_n      <= n_n;
    end

    `FC_ASSERT_ALWAYS(a_active_fill_max, i_clk, i_rst_n, r_a_fill <= ACTIVE_DEPTH, "active fill above depth")
    `FC_ASSERT_ALWAYS(a_history_fill_max, i_clk, i_rst_n, r_h_fill <= HISTORY_DEPTH, "history fill above depth")
    `FC_ASSERT_IMPL(a_history_grows, i_clk, i_rst_n, $past(i_rst_n), r_h_fill >= $past(r_h_fill), "history fill fell")
    `FC_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, o_res.load, i_out_free, "result loaded into a full output register")

endmodule

`default_nettype wire

/* tb/tb_fault_code_store.sv */
// Self-checking testbench for the fault code store: directed corners, random traffic, stalls.
`timescale 1ns / 1ps

module tb_fault_code_store;
    import fc_pkg::*;

    // Capacities of the two lists, as the block is built
    localparam int ACTIVE_SLOTS  = 8;
    localparam int HISTORY_SLOTS = 16;

    // Action codes outside the documented set; the block reports status only
    localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;

    localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 40;    // beyond the longest walk of both lists
    localparam int HOLD_CYCLES  = 300;   // long output hold-off
    localparam int MAX_REPORTS  = 10;

    // One status or read-burst result
    typedef struct packed {
        logic                   code_active;
        logic [ACT_TOTAL_W-1:0] active_total;
        logic [HIS_TOTAL_W-1:0] history_total;
        logic [OUT_CODE_W-1:0]  read_code;
        logic                   read_valid;
        logic                   last;
    } t_fc_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] action, [18:3] fault_code, [26:19] max_count, [31:27] zero
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] code_active, [4:1] active_total, [9:5] history_total, [25:10] read_code
    logic [31:0] m_axis_tdata;
    // [0] read_valid
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    fault_code_store DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Mirror of the two lists
    logic [IN_CODE_W-1:0] active_codes[$];
    logic [IN_CODE_W-1:0] history_codes[$];
    t_fc_status           status_due_q[$];
    logic [IN_CODE_W-1:0] code_pool[12];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    int items_sent    = 0;
    int results_seen  = 0;
    int entries_read  = 0;
    int empty_reads   = 0;
    int full_drops    = 0;
    int mismatch_cnt  = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Position of a code in one of the lists, -1 if absent
    function automatic int find_pos(bit in_history, logic [IN_CODE_W-1:0] code);
        int fill;
        fill = in_history ? history_codes.size() : active_codes.size();
        for (int k = 0; k < fill; k++) begin
            if ((in_history ? history_codes[k] : active_codes[k]) == code)
                return k;
        end
        return -1;
    endfunction

    // Update the list mirror for one accepted action and queue its results
    task automatic predict_action(input logic [ACTION_W-1:0] act,
                                  input logic [IN_CODE_W-1:0] code,
                                  input logic [COUNT_W-1:0] maxc);
        int         pos;
        int         n;
        bit         from_history;
        t_fc_status st;
        case (act)
            ACT_SET: begin
                if (find_pos(1'b0, code) < 0) begin
                    if (active_codes.size() < ACTIVE_SLOTS) active_codes.push_back(code);
                    else full_drops++;
                end
                if (find_pos(1'b1, code) < 0) begin
                    if (history_codes.size() < HISTORY_SLOTS) history_codes.push_back(code);
                    else full_drops++;
                end
            end
            ACT_CLEAR: begin
                pos = find_pos(1'b0, code);
                if (pos >= 0) active_codes.delete(pos);
            end
            ACT_CLEAR_ALL: active_codes.delete();
            default: ;
        endcase
        st.code_active   = (find_pos(1'b0, code) >= 0);
        st.active_total  = ACT_TOTAL_W'(active_codes.size());
        st.history_total = HIS_TOTAL_W'(history_codes.size());
        st.read_code     = '0;
        st.read_valid    = 1'b0;
        st.last          = 1'b1;
        if (act == ACT_READ_ACT || act == ACT_READ_HIST) begin
            from_history = (act == ACT_READ_HIST);
            n = from_history ? history_codes.size() : active_codes.size();
            if (int'(maxc) < n) n = int'(maxc);
            if (n == 0) empty_reads++;
            for (int k = 0; k < n; k++) begin
                st.read_code  = from_history ? history_codes[k] : active_codes[k];
                st.read_valid = 1'b1;
                st.last       = (k == n - 1);
                status_due_q.push_back(st);
            end
            entries_read += n;
            if (n != 0) return;
        end
        status_due_q.push_back(st);
    endtask

    // Compare one output transaction with the oldest expectation
    task automatic check_result();
        t_fc_status want;
        t_fc_status got;
        got.code_active   = m_axis_tdata[0];
        got.active_total  = m_axis_tdata[4:1];
        got.history_total = m_axis_tdata[9:5];
        got.read_code     = m_axis_tdata[25:10];
        got.read_valid    = m_axis_tuser[0];
        got.last          = m_axis_tlast;
        results_seen++;
        if (status_due_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: unexpected result %p", $realtime, got);
        end else begin
            want = status_due_q.pop_front();
            if (got.code_active !== want.code_active || got.active_total !== want.active_total
                || got.history_total !== want.history_total
                || got.read_code !== want.read_code || got.read_valid !== want.read_valid
                || got.last !== want.last) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: mismatch expected %p got %p", $realtime, want, got);
            end
        end
    endtask

    // Observe both channels; prediction before checking at each edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_action(s_axis_tdata[2:0], s_axis_tdata[18:3], s_axis_tdata[26:19]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    // Receiver: random stalls, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on stretches with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one action and hold it until the block takes it
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [IN_CODE_W-1:0] code,
                             input logic [COUNT_W-1:0] maxc);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, maxc, code, act};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    function automatic logic [ACTION_W-1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 30) return ACT_SET;
        if (r < 50) return ACT_CLEAR;
        if (r < 55) return ACT_CLEAR_ALL;
        if (r < 70) return ACT_QUERY;
        if (r < 82) return ACT_READ_ACT;
        if (r < 94) return ACT_READ_HIST;
        if (r < 97) return ACT_RSVD_A;
        return ACT_RSVD_B;
    endfunction

    // Mostly codes from a small pool so that clears and queries hit
    function automatic logic [IN_CODE_W-1:0] pick_code();
        if ($urandom_range(99) < 85) return code_pool[$urandom_range(11)];
        return IN_CODE_W'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 60) return COUNT_W'($urandom_range(10));
        if (r < 85) return COUNT_W'($urandom_range(20));
        return COUNT_W'($urandom_range(255));
    endfunction

    // Corners: empty reads, duplicates, full active list, middle and head clears
    task automatic test_directed();
        send_item(ACT_READ_ACT, 16'h0000, 8'hFF);
        send_item(ACT_READ_HIST, 16'hFFFF, 8'h00);
        send_item(ACT_QUERY, 16'hFFFF, 8'h00);
        send_item(ACT_CLEAR, 16'h1234, 8'h00);
        send_item(ACT_SET, 16'h0000, 8'h00);
        send_item(ACT_SET, 16'hFFFF, 8'hFF);
        send_item(ACT_SET, 16'hFFFF, 8'h00);
        send_item(ACT_QUERY, 16'hFFFF, 8'h00);
        send_item(ACT_RSVD_A, 16'hFFFF, 8'hFF);
        send_item(ACT_RSVD_B, 16'h0000, 8'hFF);
        send_item(ACT_READ_ACT, 16'h0000, 8'h00);
        send_item(ACT_READ_ACT, 16'hFFFF, 8'hFF);
        send_item(ACT_READ_HIST, 16'h0000, 8'h01);
        send_item(ACT_CLEAR, 16'h0000, 8'h00);
        // eight more sets: the last finds the active list full
        for (int k = 1; k <= 8; k++)
            send_item(ACT_SET, IN_CODE_W'(16'h0100 + k), 8'h00);
        send_item(ACT_CLEAR, 16'h0103, 8'h00);
        send_item(ACT_READ_ACT, 16'h0103, 8'h08);
        send_item(ACT_CLEAR_ALL, 16'h0105, 8'h00);
    endtask

    // Random actions under one idle/stall mix
    task automatic test_traffic(input int idle_pct, input int stall_pct, input int count);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            send_item(pick_action(), pick_code(), pick_count());
    endtask

    // Receiver holds off while long reads keep arriving back to back
    task automatic test_output_hold();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_token     = hold_token + 1;
        for (int k = 0; k < 20; k++) begin
            if (k % 4 == 3) send_item(ACT_SET, pick_code(), 8'h00);
            else send_item(ACT_READ_HIST, pick_code(), 8'hFF);
        end
    endtask

    initial begin
        code_pool[0] = 16'h0000;
        code_pool[1] = 16'hFFFF;
        for (int k = 2; k < 12; k++)
            code_pool[k] = IN_CODE_W'($urandom_range(16'hFFFF));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_traffic(0, 0, 60);
        test_traffic(59, 0, 60);
        test_traffic(0, 59, 60);
        test_traffic(12, 12, 60);
        test_output_hold();

        // Drain, then allow for any walk still in progress
        s_axis_tvalid  <= 1'b0;
        sink_stall_pct = 0;
        @(posedge i_clk);
        while (status_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d actions: directed corners, four idle/stall mixes, long output hold-off.",
                 items_sent);
        $display("Checked %0d results: %0d list entries read, %0d empty reads, %0d full-list drops.",
                 results_seen, entries_read, empty_reads, full_drops);
        if (mismatch_cnt == 0 && status_due_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatch_cnt, status_due_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
